>>> hdl/rtpp_pkg.sv
// rtpp_pkg: shared types and constants of the rtp frame packetizer
// holds beat payload structs, header field struct and config register codes
// no dependencies
package rtpp_pkg;

  // field widths
  localparam int FRAME_LENGTH_BITS = 24;
  localparam int TIME_MS_BITS      = 48;
  localparam int RTP_TS_BITS       = 32;
  localparam int SEQ_BITS          = 16;
  localparam int PAYLOAD_SIZE_BITS = 16;
  localparam int PAYLOAD_TYPE_BITS = 7;
  localparam int SOURCE_ID_BITS    = 32;
  localparam int TICKS_BITS        = 23;

  // header sequencing
  localparam int RTP_HDR_BYTES = 12;
  localparam int HDR_IDX_W     = $clog2(RTP_HDR_BYTES + 1);
  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_TYPE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_ID    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_MS = 2'd3;

  // configuration reset values
  localparam logic [PAYLOAD_SIZE_BITS-1:0] MAX_PAYLOAD_RST  = 16'd1200;
  localparam logic [PAYLOAD_TYPE_BITS-1:0] PAYLOAD_TYPE_RST = 7'd96;
  localparam logic [SOURCE_ID_BITS-1:0]    SOURCE_ID_RST    = 32'd1;
  localparam logic [TICKS_BITS-1:0]        TICKS_PER_MS_RST = 23'd90;

  // input beat
  typedef struct packed {
    logic [7:0]                   data_byte;
    logic                         frame_start;
    logic [FRAME_LENGTH_BITS-1:0] frame_length;
    logic [TIME_MS_BITS-1:0]      time_ms;
  } rtpp_in_t;

  // output beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_header;
    logic       packet_last;
    logic       frame_last;
    logic       item_done;
  } rtpp_out_t;

  // header fields of the packet being emitted
  typedef struct packed {
    logic                         marker;
    logic [PAYLOAD_TYPE_BITS-1:0] payload_type;
    logic [SEQ_BITS-1:0]          seq;
    logic [RTP_TS_BITS-1:0]       rtp_time;
    logic [SOURCE_ID_BITS-1:0]    source_id;
  } rtpp_hdr_t;

endpackage

>>> hdl/rtpp_hdr_mux.sv
// rtpp_hdr_mux: selects one byte of the 12-byte big-endian rtp header
// depends on rtpp_pkg for the header field struct and widths
module rtpp_hdr_mux
  import rtpp_pkg::*;
(
  input  logic [HDR_IDX_W-1:0] idx,
  input  rtpp_hdr_t            hdr,
  output logic [7:0]           hdr_byte
);

  // byte select by header position
  always_comb begin
    unique case (idx)
      4'd0:    hdr_byte = RTP_VERSION_BYTE;
      4'd1:    hdr_byte = {hdr.marker, hdr.payload_type};
      4'd2:    hdr_byte = hdr.seq[15:8];
      4'd3:    hdr_byte = hdr.seq[7:0];
      4'd4:    hdr_byte = hdr.rtp_time[31:24];
      4'd5:    hdr_byte = hdr.rtp_time[23:16];
      4'd6:    hdr_byte = hdr.rtp_time[15:8];
      4'd7:    hdr_byte = hdr.rtp_time[7:0];
      4'd8:    hdr_byte = hdr.source_id[31:24];
      4'd9:    hdr_byte = hdr.source_id[23:16];
      4'd10:   hdr_byte = hdr.source_id[15:8];
      4'd11:   hdr_byte = hdr.source_id[7:0];
      default: hdr_byte = 8'h00;
    endcase
  end

endmodule

>>> hdl/rtp_frame_packetizer.sv
// rtp_frame_packetizer: top level, cuts a byte stream of frames into rtp packets
// depends on rtpp_pkg and rtpp_hdr_mux
//
// usage:
//   in_*  : one frame byte per beat; the first byte of a frame has frame_start
//           set and also carries frame_length and time_ms (low 32 bits used)
//   out_* : packet stream, one byte per beat; each chunk of at most
//           max_payload_size bytes (1 if zero) follows a 12-byte rtp header
//   cfg_* : write-only registers, written while the block is idle
// throughput: a byte that continues a packet is consumed with its payload beat,
//   so a byte can enter every cycle unless the output stalls; a byte that
//   opens a packet first sends 12 header beats on the single output byte lane
// a byte is registered on entry in the input register and its first result is
//   then registered in the output register
// bytes outside a frame (or of an empty frame) are dropped with no output beat
// reset: synchronous active-low; clears sequence number, frame state and
//   valid flags, loads configuration defaults
// stall: when out_ready is low a shown output beat holds and the block stops
//   advancing but for dropped bytes; in_ready is low while a held byte waits
module rtp_frame_packetizer
  import rtpp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rtpp_in_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rtpp_out_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CMP_W = (FRAME_LENGTH_BITS > PAYLOAD_SIZE_BITS) ?
                         FRAME_LENGTH_BITS : PAYLOAD_SIZE_BITS;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(RTP_HDR_BYTES);

  // configuration registers
  logic [PAYLOAD_SIZE_BITS-1:0] max_payload_r;
  logic [PAYLOAD_TYPE_BITS-1:0] payload_type_r;
  logic [SOURCE_ID_BITS-1:0]    source_id_r;
  logic [TICKS_BITS-1:0]        ticks_per_ms_r;

  // input register
  rtpp_in_t               item_r;
  logic                   item_v_r;
  logic [RTP_TS_BITS-1:0] prod_r;

  // frame and packet state
  logic [SEQ_BITS-1:0]          seq_cnt_r, seq_cnt_nxt;
  logic [FRAME_LENGTH_BITS-1:0] frame_offset_r, frame_offset_nxt;
  logic [PAYLOAD_SIZE_BITS-1:0] chunk_left_r, chunk_left_nxt;
  logic [FRAME_LENGTH_BITS-1:0] frame_size_r, frame_size_nxt;
  logic [RTP_TS_BITS-1:0]       rtp_time_r, rtp_time_nxt;
  logic                         in_hdr_r, in_hdr_nxt;
  logic [HDR_IDX_W-1:0]         hdr_idx_r, hdr_idx_nxt;
  logic                         marker_r;
  logic [SEQ_BITS-1:0]          hdr_seq_r;

  // output register
  rtpp_out_t out_r;
  logic      out_v_r;

  logic                         out_free;
  logic                         fresh, start, drop, left_zero;
  logic [FRAME_LENGTH_BITS-1:0] eff_size, eff_off, rest;
  logic [PAYLOAD_SIZE_BITS-1:0] maxp, chunk, left_dec;
  logic                         marker;
  logic                         start_hdr, hdr_go, pay_fresh, pay_after, emit_pay;
  logic                         consume;
  logic [FRAME_LENGTH_BITS-1:0] off_inc;
  logic                         plast, flast;
  logic [HDR_IDX_W-1:0]         mux_idx;
  logic [7:0]                   hdr_byte;
  rtpp_hdr_t                    hdr;
  logic [RTP_TS_BITS-1:0]       prod_in;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r  <= MAX_PAYLOAD_RST;
      payload_type_r <= PAYLOAD_TYPE_RST;
      source_id_r    <= SOURCE_ID_RST;
      ticks_per_ms_r <= TICKS_PER_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_PAYLOAD:  max_payload_r  <= cfg_wdata[PAYLOAD_SIZE_BITS-1:0];
        CFG_PAYLOAD_TYPE: payload_type_r <= cfg_wdata[PAYLOAD_TYPE_BITS-1:0];
        CFG_SOURCE_ID:    source_id_r    <= cfg_wdata[SOURCE_ID_BITS-1:0];
        CFG_TICKS_PER_MS: ticks_per_ms_r <= cfg_wdata[TICKS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // timestamp scaling on entry, truncated to 32 bits
  assign prod_in = RTP_TS_BITS'(in_data.time_ms[RTP_TS_BITS-1:0] *
                                RTP_TS_BITS'(ticks_per_ms_r));

  // first look at a held byte
  assign out_free  = ~out_v_r | out_ready;
  assign fresh     = item_v_r & ~in_hdr_r;
  assign start     = item_r.frame_start;
  assign eff_size  = start ? item_r.frame_length : frame_size_r;
  assign eff_off   = start ? '0 : frame_offset_r;
  assign left_zero = start | (chunk_left_r == '0);
  assign drop      = fresh & (eff_off >= eff_size);

  // chunk length and marker for a new packet
  assign maxp   = (max_payload_r == '0) ? PAYLOAD_SIZE_BITS'(1) : max_payload_r;
  assign rest   = eff_size - eff_off;
  assign marker = CMP_W'(rest) <= CMP_W'(maxp);
  assign chunk  = marker ? rest[PAYLOAD_SIZE_BITS-1:0] : maxp;

  // beat selection
  assign start_hdr = fresh & ~drop & left_zero & out_free;
  assign pay_fresh = fresh & ~drop & ~left_zero & out_free;
  assign hdr_go    = item_v_r & in_hdr_r & out_free & (hdr_idx_r != HDR_LAST_IDX);
  assign pay_after = item_v_r & in_hdr_r & out_free & (hdr_idx_r == HDR_LAST_IDX);
  assign emit_pay  = pay_fresh | pay_after;
  assign consume   = drop | emit_pay;
  assign in_ready  = ~item_v_r | consume;

  // payload beat flags
  assign left_dec = chunk_left_r - PAYLOAD_SIZE_BITS'(1);
  assign off_inc  = frame_offset_r + FRAME_LENGTH_BITS'(1);
  assign plast    = (left_dec == '0);
  assign flast    = plast & (off_inc >= frame_size_r);

  // header byte lookup
  assign mux_idx          = in_hdr_r ? hdr_idx_r : '0;
  assign hdr.marker       = marker_r;
  assign hdr.payload_type = payload_type_r;
  assign hdr.seq          = hdr_seq_r;
  assign hdr.rtp_time     = rtp_time_r;
  assign hdr.source_id    = source_id_r;

  rtpp_hdr_mux u_hdr_mux (
    .idx      (mux_idx),
    .hdr      (hdr),
    .hdr_byte (hdr_byte)
  );

  // next state of frame and packet tracking
  always_comb begin
    seq_cnt_nxt      = seq_cnt_r;
    frame_offset_nxt = frame_offset_r;
    chunk_left_nxt   = chunk_left_r;
    frame_size_nxt   = frame_size_r;
    rtp_time_nxt     = rtp_time_r;
    in_hdr_nxt       = in_hdr_r;
    hdr_idx_nxt      = hdr_idx_r;
    if (fresh & start & (drop | start_hdr)) begin
      frame_size_nxt   = item_r.frame_length;
      rtp_time_nxt     = prod_r;
      frame_offset_nxt = '0;
      chunk_left_nxt   = '0;
    end
    if (start_hdr) begin
      chunk_left_nxt = chunk;
      seq_cnt_nxt    = seq_cnt_r + SEQ_BITS'(1);
      in_hdr_nxt     = 1'b1;
      hdr_idx_nxt    = HDR_IDX_W'(1);
    end
    if (hdr_go) begin
      hdr_idx_nxt = hdr_idx_r + HDR_IDX_W'(1);
    end
    if (emit_pay) begin
      chunk_left_nxt   = left_dec;
      frame_offset_nxt = off_inc;
      in_hdr_nxt       = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_cnt_r      <= '0;
      frame_offset_r <= '0;
      chunk_left_r   <= '0;
      frame_size_r   <= '0;
      rtp_time_r     <= '0;
      in_hdr_r       <= 1'b0;
      hdr_idx_r      <= '0;
      item_v_r       <= 1'b0;
      out_v_r        <= 1'b0;
    end else begin
      seq_cnt_r      <= seq_cnt_nxt;
      frame_offset_r <= frame_offset_nxt;
      chunk_left_r   <= chunk_left_nxt;
      frame_size_r   <= frame_size_nxt;
      rtp_time_r     <= rtp_time_nxt;
      in_hdr_r       <= in_hdr_nxt;
      hdr_idx_r      <= hdr_idx_nxt;
      if (in_valid & in_ready) begin
        item_v_r <= 1'b1;
      end else if (consume) begin
        item_v_r <= 1'b0;
      end
      if (start_hdr | hdr_go | emit_pay) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // input beat and packet header capture
  always_ff @(posedge clk) begin
    if (in_valid & in_ready) begin
      item_r <= in_data;
      prod_r <= prod_in;
    end
    if (start_hdr) begin
      marker_r  <= marker;
      hdr_seq_r <= seq_cnt_r;
    end
  end

  // output beat
  always_ff @(posedge clk) begin
    if (start_hdr | hdr_go) begin
      out_r.out_byte    <= hdr_byte;
      out_r.is_header   <= 1'b1;
      out_r.packet_last <= 1'b0;
      out_r.frame_last  <= 1'b0;
      out_r.item_done   <= 1'b0;
    end else if (emit_pay) begin
      out_r.out_byte    <= item_r.data_byte;
      out_r.is_header   <= 1'b0;
      out_r.packet_last <= plast;
      out_r.frame_last  <= flast;
      out_r.item_done   <= 1'b1;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

>>> hdl/rtpp_checker.sv
// rtpp_checker: port-level assertions for the rtp frame packetizer
// depends on rtpp_pkg; bound to rtp_frame_packetizer at the end of this file
module rtpp_checker
  import rtpp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input rtpp_out_t out_data
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // nothing shown right after reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // header beats never close a packet or an input byte
  a_hdr_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_header |->
      !out_data.packet_last && !out_data.frame_last && !out_data.item_done)
    else $error("header beat carries end flags");

  // every payload beat closes its input byte
  a_pay_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_header |-> out_data.item_done)
    else $error("payload beat without item_done");

  // a beat shown right after an accepted packet end is a header beat
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.packet_last ##1 out_valid |->
      out_data.is_header)
    else $error("payload beat follows packet end without a header");

endmodule

bind rtp_frame_packetizer rtpp_checker u_rtpp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> sim/testbench.sv
// testbench: self-checking bench for rtp_frame_packetizer
// drives byte beats and register writes, predicts the rtp packet stream, checks every beat
// depends on rtpp_pkg and the rtp_frame_packetizer rtl
`timescale 1ns / 100ps

module testbench;
  import rtpp_pkg::*;

  localparam int IDLE_PCT     = 33;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 480;
  localparam int PHASES       = 6;
  localparam int MAX_PRINTED  = 40;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  rtpp_in_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  rtpp_out_t              out_data;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // shared bench control
  bit calm;
  bit hold_req;
  int errors;

  // register shadows
  logic [PAYLOAD_SIZE_BITS-1:0] max_payload_shadow;
  logic [PAYLOAD_TYPE_BITS-1:0] ptype_shadow;
  logic [SOURCE_ID_BITS-1:0]    ssrc_shadow;
  logic [TICKS_BITS-1:0]        ticks_shadow;

  // packetizer state shadows
  logic [SEQ_BITS-1:0]          seq_num;
  logic [FRAME_LENGTH_BITS-1:0] frame_pos;
  logic [15:0]                  chunk_rem;
  logic [FRAME_LENGTH_BITS-1:0] frame_len;
  logic [RTP_TS_BITS-1:0]       frame_ts;

  // packet stream beats still to come out
  rtpp_out_t packet_beats_q[$];
  rtpp_out_t want;

  rtp_frame_packetizer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // generous limit on the whole run
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // append one beat at the tail of the expected stream
  function automatic void expect_beat(input rtpp_out_t b);
    packet_beats_q.insert(packet_beats_q.size(), b);
  endfunction

  // cut one input byte into expected packet beats, returns the beat count
  function automatic int packetize_byte(input rtpp_in_t beat);
    logic [15:0] maxp;
    logic [23:0] rest;
    logic [15:0] chunk;
    logic        marker;
    logic [7:0]  hdr [RTP_HDR_BYTES];
    rtpp_out_t   r;
    int          n;
    n = 0;
    if (beat.frame_start) begin
      frame_len = beat.frame_length;
      frame_ts  = beat.time_ms[31:0] * ticks_shadow;
      frame_pos = '0;
      chunk_rem = '0;
    end
    // no frame open, or it is already complete
    if (frame_pos >= frame_len) return 0;
    // new chunk: header beats ahead of the payload beat
    if (chunk_rem == 0) begin
      maxp   = (max_payload_shadow == 0) ? 16'd1 : max_payload_shadow;
      rest   = frame_len - frame_pos;
      chunk  = (rest < {8'd0, maxp}) ? rest[15:0] : maxp;
      marker = ({1'b0, frame_pos} + {9'd0, chunk}) >= {1'b0, frame_len};
      hdr = '{RTP_VERSION_BYTE, {marker, ptype_shadow}, seq_num[15:8], seq_num[7:0],
              frame_ts[31:24], frame_ts[23:16], frame_ts[15:8], frame_ts[7:0],
              ssrc_shadow[31:24], ssrc_shadow[23:16], ssrc_shadow[15:8], ssrc_shadow[7:0]};
      for (int i = 0; i < RTP_HDR_BYTES; i++) begin
        r.out_byte    = hdr[i];
        r.is_header   = 1'b1;
        r.packet_last = 1'b0;
        r.frame_last  = 1'b0;
        r.item_done   = 1'b0;
        expect_beat(r);
        n++;
      end
      seq_num   = seq_num + 16'd1;
      chunk_rem = chunk;
    end
    // payload beat
    chunk_rem     = chunk_rem - 16'd1;
    frame_pos     = frame_pos + 24'd1;
    r.out_byte    = beat.data_byte;
    r.is_header   = 1'b0;
    r.packet_last = (chunk_rem == 0);
    r.frame_last  = (chunk_rem == 0) && (frame_pos >= frame_len);
    r.item_done   = 1'b1;
    expect_beat(r);
    return n + 1;
  endfunction

  // one register write, junk above the register width must be dropped
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_MAX_PAYLOAD:  max_payload_shadow = val[PAYLOAD_SIZE_BITS-1:0];
      CFG_PAYLOAD_TYPE: ptype_shadow       = val[PAYLOAD_TYPE_BITS-1:0];
      CFG_SOURCE_ID:    ssrc_shadow        = val[SOURCE_ID_BITS-1:0];
      CFG_TICKS_PER_MS: ticks_shadow       = val[TICKS_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [15:0] mp, input logic [6:0] pt,
                             input logic [31:0] sid, input logic [22:0] tpm);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(CFG_MAX_PAYLOAD, {junk[15:0], mp});
    write_reg(CFG_PAYLOAD_TYPE, {junk[24:0], pt});
    write_reg(CFG_SOURCE_ID, sid);
    write_reg(CFG_TICKS_PER_MS, {junk[8:0], tpm});
    cfg_we <= 1'b0;
  endtask

  // offer one byte beat, valid stays up until accepted
  task automatic send_byte(input rtpp_in_t beat, output int produced);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    produced = packetize_byte(beat);
  endtask

  // stop offering and let the block empty out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (packet_beats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic rtpp_in_t make_beat(input logic [7:0] data, input logic start,
                                         input logic [23:0] len, input logic [47:0] ms);
    rtpp_in_t b;
    b.data_byte    = data;
    b.frame_start  = start;
    b.frame_length = len;
    b.time_ms      = ms;
    return b;
  endfunction

  // reset register values, stray byte before any frame, one short frame
  task automatic test_default_config();
    int produced;
    send_byte(make_beat(8'h11, 1'b0, 24'd5, 48'd7), produced);
    send_byte(make_beat(8'h01, 1'b1, 24'd3, 48'd1000), produced);
    send_byte(make_beat(8'h02, 1'b0, 24'd0, 48'd0), produced);
    send_byte(make_beat(8'h03, 1'b0, 24'd0, 48'd0), produced);
    wait_drained();
  endtask

  // register and field extremes
  task automatic test_field_extremes();
    int produced;
    load_config(16'd1, 7'd127, 32'hFFFF_FFFF, 23'h7F_FFFF);
    send_byte(make_beat(8'hFF, 1'b1, 24'd2, 48'hFFFF_FFFF_FFFF), produced);
    send_byte(make_beat(8'h00, 1'b0, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF), produced);
    // longest frame, left open and restarted later
    send_byte(make_beat(8'hA5, 1'b1, 24'hFF_FFFF, 48'h8000_0000_0001), produced);
    wait_drained();
    load_config(16'hFFFF, 7'd0, 32'd0, 23'd0);
    send_byte(make_beat(8'h5A, 1'b1, 24'd3, 48'd0), produced);
    send_byte(make_beat(8'hC3, 1'b0, 24'd0, 48'd0), produced);
    send_byte(make_beat(8'h3C, 1'b0, 24'd0, 48'd0), produced);
    wait_drained();
  endtask

  // zero payload size, byte after the frame, empty frame, restart mid frame
  task automatic test_special_cases();
    int produced;
    load_config(16'd0, 7'd35, 32'h1234_5678, 23'd48);
    send_byte(make_beat(8'h10, 1'b1, 24'd2, 48'd12345), produced);
    send_byte(make_beat(8'h20, 1'b0, 24'd0, 48'd0), produced);
    send_byte(make_beat(8'h30, 1'b0, 24'd9, 48'd0), produced);
    send_byte(make_beat(8'h40, 1'b1, 24'd0, 48'd99), produced);
    send_byte(make_beat(8'h50, 1'b0, 24'd4, 48'd0), produced);
    wait_drained();
    load_config(16'd3, 7'd100, 32'hCAFE_0001, 23'd8);
    send_byte(make_beat(8'h61, 1'b1, 24'd5, 48'd500), produced);
    send_byte(make_beat(8'h62, 1'b0, 24'd0, 48'd0), produced);
    send_byte(make_beat(8'h71, 1'b1, 24'd2, 48'd501), produced);
    send_byte(make_beat(8'h72, 1'b0, 24'd0, 48'd0), produced);
    wait_drained();
  endtask

  // long receiver hold-off while bytes keep coming
  task automatic test_output_backpressure();
    int produced;
    calm = 1'b1;
    load_config(16'd4, 7'd96, 32'h0BAD_F00D, 23'd90);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++)
      send_byte(make_beat(8'($urandom()), i == 0, 24'd40, 48'($urandom())), produced);
    wait_drained();
    calm = 1'b0;
  endtask

  // mostly whole frames, some cut short, empty, oversized or followed by stray bytes
  task automatic test_random_frames();
    rtpp_in_t    beat;
    logic [23:0] len;
    logic [15:0] mp;
    int          phase_count, kind, sent, extra, produced;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       mp = 16'($urandom_range(1, 8));
        1:       mp = 16'd0;
        2:       mp = 16'hFFFF;
        4:       mp = 16'd1;
        default: mp = 16'($urandom_range(1, 40));
      endcase
      load_config(mp, 7'($urandom()), $urandom(),
                  (phase == 2) ? 23'h7F_FFFF : 23'($urandom()));
      calm = (phase == 3);
      phase_count = 0;
      while (phase_count < RANDOM_ITEMS / PHASES) begin
        kind = $urandom_range(0, 99);
        if (kind < 5) len = '0;
        else if (kind < 10) len = 24'($urandom());
        else len = 24'($urandom_range(1, 24));
        if (len == 0) sent = 1;
        else if (len > 24) sent = $urandom_range(1, 24);
        else sent = int'(len);
        if (kind >= 10 && kind < 20 && len > 1) sent = $urandom_range(1, int'(len) - 1);
        extra = (kind >= 90 || len == 0) ? $urandom_range(1, 3) : 0;
        for (int i = 0; i < sent + extra; i++) begin
          beat.data_byte    = 8'($urandom());
          beat.frame_start  = (i == 0);
          beat.frame_length = (i == 0) ? len : 24'($urandom());
          beat.time_ms      = 48'({$urandom(), $urandom()});
          send_byte(beat, produced);
          if (produced > 0) phase_count++;
        end
      end
      wait_drained();
    end
    calm = 1'b0;
  endtask

  // receiver: random ready, or a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // check each accepted output beat against the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (packet_beats_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %p", out_data));
      end else begin
        want = packet_beats_q.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h", out_data.out_byte, want.out_byte));
        if (out_data.is_header !== want.is_header)
          report_mismatch($sformatf("is_header %b, want %b", out_data.is_header,
                                    want.is_header));
        if (out_data.packet_last !== want.packet_last)
          report_mismatch($sformatf("packet_last %b, want %b", out_data.packet_last,
                                    want.packet_last));
        if (out_data.frame_last !== want.frame_last)
          report_mismatch($sformatf("frame_last %b, want %b", out_data.frame_last,
                                    want.frame_last));
        if (out_data.item_done !== want.item_done)
          report_mismatch($sformatf("item_done %b, want %b", out_data.item_done,
                                    want.item_done));
      end
    end
  end

  // test sequence
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_MAX_PAYLOAD;
    cfg_wdata = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    errors    = 0;
    max_payload_shadow = MAX_PAYLOAD_RST;
    ptype_shadow       = PAYLOAD_TYPE_RST;
    ssrc_shadow        = SOURCE_ID_RST;
    ticks_shadow       = TICKS_PER_MS_RST;
    seq_num   = '0;
    frame_pos = '0;
    chunk_rem = '0;
    frame_len = '0;
    frame_ts  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_config();
    test_field_extremes();
    test_special_cases();
    test_output_backpressure();
    test_random_frames();
    wait_drained();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
